/* hw/rtl/embedding_dot_product_engine_top_defines.svh */
// Assertion macros for the embedding dot-product engine checker.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef EMBEDDING_DOT_PRODUCT_ENGINE_TOP_DEFINES_SVH
`define EMBEDDING_DOT_PRODUCT_ENGINE_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define EDP_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define EDP_CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

/* hw/rtl/edp_pkg.sv */
// Shared types and constants of the embedding dot-product engine.
// No dependencies; every other file of the block but the assertion macro header refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package edp_pkg;

	localparam int SCORE_W = 40;
	localparam int WEIGHT_FIELD_W = 16;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_INDEX_W = 2;

	localparam logic [1:0] ACT_EMB_WRITE = 2'd0;
	localparam logic [1:0] ACT_OUT_WRITE = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_VOCAB_USED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HIDDEN_USED = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_USED = 2'd2;

	localparam logic [10:0] VOCAB_USED_RST = 11'd1024;
	localparam logic [6:0] HIDDEN_USED_RST = 7'd64;
	localparam logic [6:0] OUT_USED_RST = 7'd64;

	typedef struct packed {
		logic [1:0] action;
		logic [9:0] entry_row;
		logic [5:0] entry_column;
		logic signed [WEIGHT_FIELD_W-1:0] weight_value;
		logic [9:0] word_index;
	} item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [5:0] output_position;
		logic found;
		logic last;
	} result_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic kill;
	} issue_t;

	typedef struct packed {
		logic load;
		logic found;
		logic last;
		logic [5:0] position;
	} emit_t;

endpackage

`default_nettype wire

/* hw/rtl/edp_store.sv */
// Weight memories: the embedding table and the output table, one write and one read port each.
// Depends on edp_pkg for the request type and action codes.
`timescale 1ns / 1ps
`default_nettype none

module edp_store #(
	parameter int VOCAB_DEPTH = 1024,
	parameter int HIDDEN_MAX = 64,
	parameter int OUT_MAX = 64,
	parameter int WEIGHT_BITS = 16
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire edp_pkg::item_t item,
	input wire logic [((VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1)
		+ ((HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1)-1:0] emb_raddr,
	input wire logic [((OUT_MAX > 1) ? $clog2(OUT_MAX) : 1)
		+ ((HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1)-1:0] out_raddr,
	output logic signed [((WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W)-1:0] emb_rd,
	output logic signed [((WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W)-1:0] out_rd
);

	localparam int RW = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
	localparam int CW = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
	localparam int PW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
	localparam int WB = (WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W;
	localparam int EMB_DEPTH = VOCAB_DEPTH * (1 << CW);
	localparam int OUT_DEPTH = OUT_MAX * (1 << CW);

	logic [WB-1:0] emb_mem [EMB_DEPTH];
	logic [WB-1:0] out_mem [OUT_DEPTH];
	logic [WB-1:0] emb_rd_q;
	logic [WB-1:0] out_rd_q;
	logic [16:0] row_ext;
	logic col_ok;
	logic emb_we;
	logic out_we;
	logic [RW+CW-1:0] emb_waddr;
	logic [PW+CW-1:0] out_waddr;
	logic [WB-1:0] wdata;

	always_comb begin
		row_ext = 17'(item.entry_row);
		col_ok = 7'(item.entry_column) < 7'(HIDDEN_MAX);
		emb_we = wr_en && (item.action == edp_pkg::ACT_EMB_WRITE) && col_ok
			&& (row_ext < 17'(VOCAB_DEPTH));
		out_we = wr_en && (item.action == edp_pkg::ACT_OUT_WRITE) && col_ok
			&& (row_ext < 17'(OUT_MAX));
		emb_waddr = {row_ext[RW-1:0], item.entry_column[CW-1:0]};
		out_waddr = {item.entry_row[PW-1:0], item.entry_column[CW-1:0]};
		wdata = item.weight_value[WB-1:0];
	end

	always_ff @(posedge clk) begin
		if (emb_we) begin
			emb_mem[emb_waddr] <= wdata;
		end
		emb_rd_q <= emb_mem[emb_raddr];
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			out_mem[out_waddr] <= wdata;
		end
		out_rd_q <= out_mem[out_raddr];
	end

	assign emb_rd = emb_rd_q;
	assign out_rd = out_rd_q;

endmodule

`default_nettype wire

/* hw/rtl/edp_mac.sv */
// Shared multiply-accumulate unit: one product per cycle summed into a 40-bit score.
// Depends on edp_pkg for the issue control type and the score width.
`timescale 1ns / 1ps
`default_nettype none

module edp_mac #(
	parameter int WEIGHT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire edp_pkg::issue_t issue,
	input wire logic signed [((WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W)-1:0] emb_w,
	input wire logic signed [((WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W)-1:0] out_w,
	output logic [edp_pkg::SCORE_W-1:0] acc,
	output logic done
);

	localparam int WB = (WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W;

	edp_pkg::issue_t ctrl_s1;
	edp_pkg::issue_t ctrl_s2;
	logic signed [2*WB-1:0] prod_s2;
	logic [edp_pkg::SCORE_W-1:0] acc_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctrl_s1 <= issue;
			ctrl_s2 <= ctrl_s1;
			if (issue.valid && issue.first) begin
				done_q <= 1'b0;
			end else if (ctrl_s2.valid && ctrl_s2.last) begin
				done_q <= 1'b1;
			end
		end
	end

	// The product of a killed term is forced to zero, giving an empty sum.
	always_ff @(posedge clk) begin
		if (ctrl_s1.kill) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= emb_w * out_w;
		end
		if (ctrl_s2.valid) begin
			acc_q <= (ctrl_s2.first ? '0 : acc_q) + edp_pkg::SCORE_W'(prod_s2);
		end
	end

	assign acc = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* hw/rtl/edp_seq.sv */
// Sequencer: accepts requests, walks output positions and terms, and hands results over.
// Depends on edp_pkg for the request, issue and result-load types and the action codes.
`timescale 1ns / 1ps
`default_nettype none

module edp_seq #(
	parameter int VOCAB_DEPTH = 1024,
	parameter int HIDDEN_MAX = 64,
	parameter int OUT_MAX = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire edp_pkg::item_t item,
	output logic item_ready,
	input wire logic [10:0] vocab_used,
	input wire logic [6:0] hidden_used,
	input wire logic [6:0] out_used,
	input wire logic mac_done,
	input wire logic out_free,
	output edp_pkg::issue_t issue,
	output logic [((VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1)
		+ ((HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1)-1:0] emb_raddr,
	output logic [((OUT_MAX > 1) ? $clog2(OUT_MAX) : 1)
		+ ((HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1)-1:0] out_raddr,
	output edp_pkg::emit_t emit
);

	localparam int RW = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
	localparam int CW = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
	localparam int PW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_RUN = 3'b010,
		SQ_WAIT = 3'b100
	} seq_state_t;

	seq_state_t state_q;
	logic [RW-1:0] word_q;
	logic [CW-1:0] m_q;
	logic [PW-1:0] p_q;
	logic [6:0] nterm_q;
	logic [6:0] npos_q;
	logic kill_q;
	logic found_q;

	logic [16:0] word_ext;
	logic start;
	logic hit;
	logic [6:0] h_sat;
	logic [6:0] o_sat;
	logic m_last;
	logic p_last;

	always_comb begin
		word_ext = 17'(item.word_index);
		item_ready = (state_q == SQ_IDLE);
		start = item_valid && item_ready && (item.action == edp_pkg::ACT_QUERY);
		hit = (11'(item.word_index) < vocab_used) && (word_ext < 17'(VOCAB_DEPTH));
		h_sat = (hidden_used > 7'(HIDDEN_MAX)) ? 7'(HIDDEN_MAX) : hidden_used;
		o_sat = (out_used > 7'(OUT_MAX)) ? 7'(OUT_MAX) : out_used;
		if (o_sat == 7'd0) begin
			o_sat = 7'd1;
		end
		m_last = (7'(m_q) == nterm_q - 7'd1);
		p_last = (7'(p_q) == npos_q - 7'd1);

		issue.valid = (state_q == SQ_RUN);
		issue.first = (m_q == '0);
		issue.last = m_last;
		issue.kill = kill_q;
		emb_raddr = {word_q, m_q};
		out_raddr = {p_q, m_q};

		emit.load = (state_q == SQ_WAIT) && (!found_q || mac_done) && out_free;
		emit.found = found_q;
		emit.last = !found_q || p_last;
		emit.position = found_q ? 6'(p_q) : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			m_q <= '0;
			p_q <= '0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						m_q <= '0;
						p_q <= '0;
						state_q <= hit ? SQ_RUN : SQ_WAIT;
					end
				end
				SQ_RUN: begin
					if (m_last) begin
						state_q <= SQ_WAIT;
					end else begin
						m_q <= m_q + 1'b1;
					end
				end
				SQ_WAIT: begin
					if (emit.load) begin
						if (emit.last) begin
							state_q <= SQ_IDLE;
						end else begin
							p_q <= p_q + 1'b1;
							m_q <= '0;
							state_q <= SQ_RUN;
						end
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	// With no terms in use a single killed term still runs, so the score is zero.
	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= word_ext[RW-1:0];
			found_q <= hit;
			kill_q <= (h_sat == 7'd0);
			nterm_q <= (h_sat == 7'd0) ? 7'd1 : h_sat;
			npos_q <= o_sat;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/embedding_dot_product_engine_top.sv */
// Top level of the embedding dot-product engine: configuration registers and result register.
// Depends on edp_pkg, edp_store, edp_mac and edp_seq.
//
// Channel  Direction  Signals                                  Moves
// item     in         item_valid, item_ready, item             load or query request
// result   out        result_valid, result_ready, result       one score per request step
// cfg      in         cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// A load request is written on its handshake and leaves the item channel ready. A query runs
// its terms through the single multiply-accumulate unit, one term per cycle in the run state;
// a word outside the vocabulary gives one not-found result. The item channel is not ready
// while a query runs. A stalled result holds the sequencer until the result register frees.
// Reset restores the registers to 1024, 64 and 64; the weight tables are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module embedding_dot_product_engine_top #(
	parameter int VOCAB_DEPTH = 1024,
	parameter int HIDDEN_MAX = 64,
	parameter int OUT_MAX = 64,
	parameter int WEIGHT_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire edp_pkg::item_t item,
	output logic result_valid,
	input wire logic result_ready,
	output edp_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [edp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [edp_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int RW = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
	localparam int CW = (HIDDEN_MAX > 1) ? $clog2(HIDDEN_MAX) : 1;
	localparam int PW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
	localparam int WB = (WEIGHT_BITS < edp_pkg::WEIGHT_FIELD_W) ? WEIGHT_BITS
		: edp_pkg::WEIGHT_FIELD_W;

	logic [10:0] vocab_used_q;
	logic [6:0] hidden_used_q;
	logic [6:0] out_used_q;
	logic result_valid_q;
	edp_pkg::result_t result_q;

	logic item_ready_w;
	logic out_free;
	edp_pkg::issue_t issue;
	edp_pkg::emit_t emit;
	logic [RW+CW-1:0] emb_raddr;
	logic [PW+CW-1:0] out_raddr;
	logic signed [WB-1:0] emb_rd;
	logic signed [WB-1:0] out_rd;
	logic [edp_pkg::SCORE_W-1:0] mac_acc;
	logic mac_done;

	assign cfg_ready = 1'b1;
	assign item_ready = item_ready_w;
	assign out_free = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_used_q <= edp_pkg::VOCAB_USED_RST;
			hidden_used_q <= edp_pkg::HIDDEN_USED_RST;
			out_used_q <= edp_pkg::OUT_USED_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				edp_pkg::CFG_VOCAB_USED: vocab_used_q <= cfg_data;
				edp_pkg::CFG_HIDDEN_USED: hidden_used_q <= cfg_data[6:0];
				edp_pkg::CFG_OUT_USED: out_used_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit.load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			result_q.score <= emit.found ? mac_acc : '0;
			result_q.output_position <= emit.position;
			result_q.found <= emit.found;
			result_q.last <= emit.last;
		end
	end

	edp_seq #(
		.VOCAB_DEPTH(VOCAB_DEPTH),
		.HIDDEN_MAX(HIDDEN_MAX),
		.OUT_MAX(OUT_MAX)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item(item),
		.item_ready(item_ready_w),
		.vocab_used(vocab_used_q),
		.hidden_used(hidden_used_q),
		.out_used(out_used_q),
		.mac_done(mac_done),
		.out_free(out_free),
		.issue(issue),
		.emb_raddr(emb_raddr),
		.out_raddr(out_raddr),
		.emit(emit)
	);

	edp_store #(
		.VOCAB_DEPTH(VOCAB_DEPTH),
		.HIDDEN_MAX(HIDDEN_MAX),
		.OUT_MAX(OUT_MAX),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_store (
		.clk(clk),
		.wr_en(item_valid && item_ready_w),
		.item(item),
		.emb_raddr(emb_raddr),
		.out_raddr(out_raddr),
		.emb_rd(emb_rd),
		.out_rd(out_rd)
	);

	edp_mac #(
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.issue(issue),
		.emb_w(emb_rd),
		.out_w(out_rd),
		.acc(mac_acc),
		.done(mac_done)
	);

endmodule

`default_nettype wire

/* hw/rtl/edp_checker.sv */
// Port-level checker for the embedding dot-product engine, bound to the top level.
// Depends on edp_pkg and the assertion macros in embedding_dot_product_engine_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "embedding_dot_product_engine_top_defines.svh"

module edp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire edp_pkg::item_t item,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire edp_pkg::result_t result,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [edp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [edp_pkg::CFG_DATA_W-1:0] cfg_data
);

	`EDP_CHECK_ALWAYS(a_no_result_in_reset, !arst_n |-> !result_valid, "result shown during reset")
	`EDP_CHECK(a_result_held, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")
	`EDP_CHECK(a_miss_shape, result_valid && !result.found |-> result.last && result.score == 0 && result.output_position == 0, "bad not-found result")
	`EDP_CHECK(a_query_busy, item_valid && item_ready && item.action == edp_pkg::ACT_QUERY |=> !item_ready, "query did not block the item channel")
	`EDP_CHECK(a_load_silent, item_valid && item_ready && item.action != edp_pkg::ACT_QUERY && !result_valid |=> !result_valid, "load request produced a result")

endmodule

bind embedding_dot_product_engine_top edp_checker u_edp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.item(item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_index(cfg_index),
	.cfg_data(cfg_data)
);

`default_nettype wire
